// ----- sv/tlut_act_pkg.sv -----
// Shared constants and types for the two-level table-lookup activation block.
`default_nettype none

package tlut_act_pkg;

    // Default sizes of the datapath and the tables
    localparam int DEF_DATA_WIDTH   = 16;
    localparam int DEF_ADDR_BITS    = 12;
    localparam int DEF_FINE_BITS    = 4;
    localparam int DEF_COARSE_WIDTH = 16;

    // Fixed widths of the request fields
    localparam int REQ_WIDTH       = 2;
    localparam int INDEX_WIDTH     = 12;
    localparam int WORD_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    // Request codes carried with each input word
    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_EVAL   = 2'd0,
        REQ_FINE   = 2'd1,
        REQ_COARSE = 2'd2
    } req_type_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LOWER_LIMIT     = 3'd0,
        CFG_UPPER_LIMIT     = 3'd1,
        CFG_LINEAR_ABOVE    = 3'd2,
        CFG_SYMMETRIC_MODE  = 3'd3,
        CFG_BELOW_VALUE     = 3'd4,
        CFG_ABOVE_VALUE     = 3'd5,
        CFG_MIRROR_CONSTANT = 3'd6
    } cfg_index_t;

    // Per-sample control that travels down the pipeline with the word
    typedef struct packed {
        logic use_table;  // in range: result comes from the tables
        logic mirror;     // symmetric mode, negative sample
    } stage_ctl_t;

endpackage : tlut_act_pkg

`default_nettype wire

// ----- sv/tlut_act_tables.sv -----
// Fine and coarse lookup tables: one write port and one registered read port each.
`default_nettype none

module tlut_act_tables #(
    parameter int ADDR_BITS    = 12,
    parameter int FINE_BITS    = 4,
    parameter int COARSE_WIDTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               fine_we,
    input  wire logic [ADDR_BITS-1:0]               fine_waddr,
    input  wire logic [FINE_BITS-1:0]               fine_wdata,
    input  wire logic                               coarse_we,
    input  wire logic [ADDR_BITS-FINE_BITS-1:0]     coarse_waddr,
    input  wire logic [COARSE_WIDTH-1:0]            coarse_wdata,
    input  wire logic                               rd_en,
    input  wire logic [ADDR_BITS-1:0]               rd_addr,
    output logic      [FINE_BITS-1:0]               fine_q,
    output logic      [COARSE_WIDTH-1:0]            coarse_q
);

    localparam int FINE_DEPTH   = 1 << ADDR_BITS;
    localparam int COARSE_DEPTH = 1 << (ADDR_BITS - FINE_BITS);

    logic [FINE_BITS-1:0]    fine_mem   [FINE_DEPTH];
    logic [COARSE_WIDTH-1:0] coarse_mem [COARSE_DEPTH];

    logic [FINE_BITS-1:0]    fine_q_reg;
    logic [COARSE_WIDTH-1:0] coarse_q_reg;

    // Fine table: write, then registered read at the full address
    always_ff @(posedge aclk) begin
        if (fine_we) begin
            fine_mem[fine_waddr] <= fine_wdata;
        end
        if (rd_en) begin
            fine_q_reg <= fine_mem[rd_addr];
        end
    end

    // Coarse table: indexed by the address with the fine bits dropped
    always_ff @(posedge aclk) begin
        if (coarse_we) begin
            coarse_mem[coarse_waddr] <= coarse_wdata;
        end
        if (rd_en) begin
            coarse_q_reg <= coarse_mem[rd_addr[ADDR_BITS-1:FINE_BITS]];
        end
    end

    assign fine_q   = fine_q_reg;
    assign coarse_q = coarse_q_reg;

endmodule : tlut_act_tables

`default_nettype wire

// ----- sv/tlut_act_out.sv -----
// Back end: table sum, mirroring and the output register.
`default_nettype none

module tlut_act_out #(
    parameter int DATA_WIDTH   = 16,
    parameter int FINE_BITS    = 4,
    parameter int COARSE_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // read stage
    input  wire logic                           s1_valid,
    input  wire tlut_act_pkg::stage_ctl_t       s1_ctl,
    input  wire logic [DATA_WIDTH-1:0]          s1_const,
    input  wire logic [FINE_BITS-1:0]           fine_q,
    input  wire logic [COARSE_WIDTH-1:0]        coarse_q,
    output logic                                s1_take,
    // configuration
    input  wire logic [DATA_WIDTH-1:0]          mirror_constant,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [DATA_WIDTH-1:0]          m_result
);

    import tlut_act_pkg::*;

    localparam int CEXT_W = (COARSE_WIDTH > DATA_WIDTH) ? COARSE_WIDTH : DATA_WIDTH;

    logic                   v2_reg;
    stage_ctl_t             ctl2_reg;
    logic [DATA_WIDTH-1:0]  const2_reg;
    logic [DATA_WIDTH-1:0]  sum2_reg;
    logic [DATA_WIDTH-1:0]  sum2_next;

    logic                   m_valid_reg;
    logic [DATA_WIDTH-1:0]  m_result_reg;
    logic [DATA_WIDTH-1:0]  m_result_next;

    logic                   out_take;
    logic signed [CEXT_W-1:0] coarse_ext;

    // stall control
    assign out_take = !m_valid_reg || m_ready;
    assign s1_take  = !v2_reg || out_take;

    // coarse entry taken as signed, then added to the zero-extended fine entry
    always_comb begin
        coarse_ext = CEXT_W'(signed'(coarse_q));
        sum2_next  = coarse_ext[DATA_WIDTH-1:0] + DATA_WIDTH'(fine_q);
    end

    // sum stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (s1_take) begin
            v2_reg <= s1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_take) begin
            ctl2_reg   <= s1_ctl;
            const2_reg <= s1_const;
            sum2_reg   <= sum2_next;
        end
    end

    // final select
    always_comb begin
        priority if (!ctl2_reg.use_table) begin
            m_result_next = const2_reg;
        end else if (ctl2_reg.mirror) begin
            m_result_next = mirror_constant - sum2_reg;
        end else begin
            m_result_next = sum2_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_take) begin
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            m_result_reg <= m_result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

`ifndef SYNTHESIS
    // a word held in the sum stage is not dropped while the output is blocked
    a_sum_held: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !s1_take |=> v2_reg)
        else $error("sum stage word lost under stall");

    // a new result only appears from a valid sum stage
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v2_reg))
        else $error("result produced without a source word");

    // the read stage is only refused while both downstream registers are full
    a_take_cond: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_take |-> (v2_reg && m_valid_reg && !m_ready))
        else $error("read stage stalled with room downstream");
`endif

endmodule : tlut_act_out

`default_nettype wire

// ----- sv/two_level_lut_activation.sv -----
// Top level of the two-level table-lookup activation block.
`default_nettype none

// Evaluates a nonlinear function on signed fixed-point samples. Samples below
// lower_limit return below_value; samples above upper_limit return above_value
// or the sample itself when linear_above is set. Other samples look up a coarse
// entry (address without its fine bits, signed) plus a fine entry (unsigned);
// in symmetric mode the address is the absolute value and negative samples
// return mirror_constant minus that sum. Table loads come in on the same input
// channel as samples and take effect for every later word. One word is accepted
// per clock unless the result channel stalls; an evaluated sample is presented
// on the result channel after its table read at the accepting edge, then sum,
// then select into the output register. The rate is set by the single read
// port of each table, read at the acceptance edge. Tables are not cleared: every
// entry a sample touches must be loaded first. Requires ADDR_BITS > FINE_BITS.
module two_level_lut_activation #(
    parameter int DATA_WIDTH   = tlut_act_pkg::DEF_DATA_WIDTH,
    parameter int ADDR_BITS    = tlut_act_pkg::DEF_ADDR_BITS,
    parameter int FINE_BITS    = tlut_act_pkg::DEF_FINE_BITS,
    parameter int COARSE_WIDTH = tlut_act_pkg::DEF_COARSE_WIDTH
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    // configuration port
    input  wire logic                                       cfg_we,
    input  wire logic [tlut_act_pkg::CFG_INDEX_WIDTH-1:0]   cfg_addr,
    input  wire logic [DATA_WIDTH-1:0]                      cfg_wdata,
    // input channel
    input  wire logic                                       s_valid,
    output logic                                            s_ready,
    input  wire logic [tlut_act_pkg::REQ_WIDTH-1:0]         s_req_type,
    input  wire logic signed [DATA_WIDTH-1:0]               s_sample,
    input  wire logic [tlut_act_pkg::INDEX_WIDTH-1:0]       s_entry_index,
    input  wire logic [tlut_act_pkg::WORD_WIDTH-1:0]        s_entry_word,
    // result channel
    output logic                                            m_valid,
    input  wire logic                                       m_ready,
    output logic signed [DATA_WIDTH-1:0]                    m_result
);

    import tlut_act_pkg::*;

    localparam int COARSE_AW    = ADDR_BITS - FINE_BITS;
    localparam int COARSE_DEPTH = 1 << COARSE_AW;
    localparam int TGT_W = (DATA_WIDTH > ADDR_BITS) ? DATA_WIDTH : ADDR_BITS;
    localparam int IDX_W = (INDEX_WIDTH > ADDR_BITS) ? INDEX_WIDTH : ADDR_BITS;

    // configuration registers
    logic signed [DATA_WIDTH-1:0] lower_limit_reg;
    logic signed [DATA_WIDTH-1:0] upper_limit_reg;
    logic                         linear_above_reg;
    logic                         symmetric_mode_reg;
    logic [DATA_WIDTH-1:0]        below_value_reg;
    logic [DATA_WIDTH-1:0]        above_value_reg;
    logic [DATA_WIDTH-1:0]        mirror_constant_reg;

    // input decode
    logic                   accept;
    logic                   is_eval;
    logic                   is_below;
    logic                   is_above;
    logic                   is_neg;
    logic [DATA_WIDTH-1:0]  target;
    logic [TGT_W-1:0]       target_ext;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [DATA_WIDTH-1:0]  const_next;
    stage_ctl_t             ctl_next;
    logic [IDX_W-1:0]       index_ext;
    logic                   coarse_in_range;

    // read stage
    logic                   v1_reg;
    stage_ctl_t             ctl1_reg;
    logic [DATA_WIDTH-1:0]  const1_reg;
    logic                   s1_take;

    logic [FINE_BITS-1:0]    fine_q;
    logic [COARSE_WIDTH-1:0] coarse_q;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_limit_reg     <= '0;
            upper_limit_reg     <= '0;
            linear_above_reg    <= 1'b0;
            symmetric_mode_reg  <= 1'b0;
            below_value_reg     <= '0;
            above_value_reg     <= '0;
            mirror_constant_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LOWER_LIMIT:     lower_limit_reg     <= cfg_wdata;
                CFG_UPPER_LIMIT:     upper_limit_reg     <= cfg_wdata;
                CFG_LINEAR_ABOVE:    linear_above_reg    <= cfg_wdata[0];
                CFG_SYMMETRIC_MODE:  symmetric_mode_reg  <= cfg_wdata[0];
                CFG_BELOW_VALUE:     below_value_reg     <= cfg_wdata;
                CFG_ABOVE_VALUE:     above_value_reg     <= cfg_wdata;
                CFG_MIRROR_CONSTANT: mirror_constant_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake
    assign s_ready = !v1_reg || s1_take;
    assign accept  = s_valid && s_ready;
    assign is_eval = (s_req_type == REQ_EVAL);

    // range check and table address
    always_comb begin
        is_below = s_sample < lower_limit_reg;
        is_above = s_sample > upper_limit_reg;
        is_neg   = s_sample[DATA_WIDTH-1];
        if (symmetric_mode_reg) begin
            target = is_neg ? (DATA_WIDTH'(0) - s_sample) : s_sample;
        end else begin
            target = s_sample - lower_limit_reg;
        end
        target_ext = TGT_W'(target);
        rd_addr    = target_ext[ADDR_BITS-1:0];
    end

    // constant results and control for the later stages
    always_comb begin
        priority if (is_below) begin
            const_next = below_value_reg;
        end else if (linear_above_reg) begin
            const_next = s_sample;
        end else begin
            const_next = above_value_reg;
        end
        ctl_next.use_table = !is_below && !is_above;
        ctl_next.mirror    = symmetric_mode_reg && is_neg;
    end

    // table load decode
    always_comb begin
        index_ext       = IDX_W'(s_entry_index);
        coarse_in_range = 32'(s_entry_index) < 32'(COARSE_DEPTH);
    end

    // read stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid && is_eval;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            ctl1_reg   <= ctl_next;
            const1_reg <= const_next;
        end
    end

    tlut_act_tables #(
        .ADDR_BITS    (ADDR_BITS),
        .FINE_BITS    (FINE_BITS),
        .COARSE_WIDTH (COARSE_WIDTH)
    ) u_tables (
        .aclk         (aclk),
        .fine_we      (accept && (s_req_type == REQ_FINE)),
        .fine_waddr   (index_ext[ADDR_BITS-1:0]),
        .fine_wdata   (s_entry_word[FINE_BITS-1:0]),
        .coarse_we    (accept && (s_req_type == REQ_COARSE) && coarse_in_range),
        .coarse_waddr (index_ext[COARSE_AW-1:0]),
        .coarse_wdata (COARSE_WIDTH'(s_entry_word)),
        .rd_en        (s_ready),
        .rd_addr      (rd_addr),
        .fine_q       (fine_q),
        .coarse_q     (coarse_q)
    );

    tlut_act_out #(
        .DATA_WIDTH   (DATA_WIDTH),
        .FINE_BITS    (FINE_BITS),
        .COARSE_WIDTH (COARSE_WIDTH)
    ) u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s1_valid        (v1_reg),
        .s1_ctl          (ctl1_reg),
        .s1_const        (const1_reg),
        .fine_q          (fine_q),
        .coarse_q        (coarse_q),
        .s1_take         (s1_take),
        .mirror_constant (mirror_constant_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result        (m_result)
    );

`ifndef SYNTHESIS
    // table loads and unused codes never enter the result pipeline
    a_no_result_for_load: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_eval |=> !v1_reg)
        else $error("load word entered the result pipeline");

    // a sample waiting in the read stage is kept while the back end is full
    a_read_held: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !s1_take |=> v1_reg && $stable(ctl1_reg))
        else $error("read stage word lost under stall");
`endif

endmodule : two_level_lut_activation

`default_nettype wire
